// ===== sv/lsws_pkg.sv =====
// shared constants, codes and controller/datapath interface types for the search stack
package lsws_pkg;

	localparam int DEPTH      = 64;
	localparam int WORD_BITS  = 32;
	localparam int ADDR_W     = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int DATA_W     = 32;
	localparam int FUNC_W     = 2;
	localparam int STATUS_W   = 2;
	localparam int CAP_W      = 7;
	localparam int OUT_BITS   = DATA_W + 1 + CNT_W + 1 + 1;
	localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

	localparam logic [FUNC_W-1:0] OP_PUSH   = 2'd0;
	localparam logic [FUNC_W-1:0] OP_POP    = 2'd1;
	localparam logic [FUNC_W-1:0] OP_SEARCH = 2'd2;

	localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	// commands from the controller to the datapath
	typedef struct packed {
		logic take_in;    // latch the input word
		logic exec;       // decide the operation, update count, issue first read
		logic pop_latch;  // capture the popped word from the read register
		logic srch_step;  // compare one entry and read the next
		logic out_load;   // move the result into the output register
	} cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic              empty;     // no stored entries
		logic              match;     // current search entry equals the key
		logic              last;      // current search entry is the top one
		logic              out_free;  // output register can take a word
	} sts_t;

endpackage

// ===== sv/lsws_ctrl.sv =====
// controller state machine sequencing push, pop and the entry-by-entry search
module lsws_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  lsws_pkg::sts_t       sts,
	output lsws_pkg::cmd_t       cmd
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_EXEC = 5'b00010,
		S_RDWT = 5'b00100,
		S_SRCH = 5'b01000,
		S_FIN  = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take_in = 1'b1;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				case (sts.func)
					lsws_pkg::OP_POP:    state_d = sts.empty ? S_FIN : S_RDWT;
					lsws_pkg::OP_SEARCH: state_d = sts.empty ? S_FIN : S_SRCH;
					default:             state_d = S_FIN;
				endcase
			end
			S_RDWT: begin
				cmd.pop_latch = 1'b1;
				state_d = S_FIN;
			end
			S_SRCH: begin
				cmd.srch_step = 1'b1;
				if (sts.match || sts.last) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== sv/lsws_dp.sv =====
// datapath: entry memory, count, capacity register, search walk and output register
module lsws_dp (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  lsws_pkg::cmd_t                        cmd,
	output lsws_pkg::sts_t                        sts,
	input  logic                                  cfg_write,
	input  logic [lsws_pkg::CAP_W-1:0]            cfg_cap,
	input  logic [lsws_pkg::FUNC_W-1:0]           in_func,
	input  logic [lsws_pkg::DATA_W-1:0]           in_value,
	input  logic                                  out_ready,
	output logic                                  out_valid,
	output logic [lsws_pkg::OUT_TDATA_W-1:0]      out_data,
	output logic [lsws_pkg::STATUS_W-1:0]         out_status
);

	logic [lsws_pkg::WORD_BITS-1:0] mem [lsws_pkg::DEPTH];
	logic [lsws_pkg::WORD_BITS-1:0] rd_data_q;

	logic [lsws_pkg::CAP_W-1:0]     cap_q;
	logic [lsws_pkg::CNT_W-1:0]     count_q;
	logic [lsws_pkg::FUNC_W-1:0]    func_q;
	logic [lsws_pkg::WORD_BITS-1:0] key_q;
	logic [lsws_pkg::ADDR_W-1:0]    idx_q;
	logic [lsws_pkg::STATUS_W-1:0]  status_q;
	logic [lsws_pkg::DATA_W-1:0]    data_q;
	logic                           found_q;

	logic                                 out_valid_q;
	logic [lsws_pkg::OUT_TDATA_W-1:0]     out_data_q;
	logic [lsws_pkg::STATUS_W-1:0]        out_status_q;

	logic [lsws_pkg::CNT_W-1:0]     eff_cap;
	logic                           full;
	logic                           empty;
	logic [lsws_pkg::CNT_W-1:0]     count_dec;
	logic                           rd_en;
	logic [lsws_pkg::ADDR_W-1:0]    rd_addr;
	logic [lsws_pkg::ADDR_W-1:0]    idx_inc;

	// capacity above the memory depth saturates
	assign eff_cap = (lsws_pkg::CNT_W'(cap_q) > lsws_pkg::CNT_W'(lsws_pkg::DEPTH))
		? lsws_pkg::CNT_W'(lsws_pkg::DEPTH) : lsws_pkg::CNT_W'(cap_q);
	assign full      = (count_q >= eff_cap);
	assign empty     = (count_q == '0);
	assign count_dec = count_q - 1'b1;
	assign idx_inc   = idx_q + 1'b1;

	assign sts.func     = func_q;
	assign sts.empty    = empty;
	assign sts.match    = (rd_data_q == key_q);
	assign sts.last     = ((lsws_pkg::CNT_W'(idx_q) + 1'b1) == count_q);
	assign sts.out_free = !out_valid_q || out_ready;

	always_comb begin
		rd_en = 1'b0;
		rd_addr = '0;
		if (cmd.exec && func_q == lsws_pkg::OP_POP) begin
			rd_en = 1'b1;
			rd_addr = count_dec[lsws_pkg::ADDR_W-1:0];
		end else if (cmd.exec && func_q == lsws_pkg::OP_SEARCH) begin
			rd_en = 1'b1;
		end else if (cmd.srch_step) begin
			rd_en = 1'b1;
			rd_addr = idx_inc;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && func_q == lsws_pkg::OP_PUSH && !full) begin
			mem[count_q[lsws_pkg::ADDR_W-1:0]] <= key_q;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= lsws_pkg::CAP_RESET;
			count_q <= '0;
		end else begin
			if (cfg_write) begin
				cap_q <= cfg_cap;
			end
			if (cmd.exec) begin
				if (func_q == lsws_pkg::OP_PUSH && !full) begin
					count_q <= count_q + 1'b1;
				end else if (func_q == lsws_pkg::OP_POP && !empty) begin
					count_q <= count_dec;
				end
			end
		end
	end

	// operation registers
	always_ff @(posedge clk) begin
		if (cmd.take_in) begin
			func_q <= in_func;
			key_q  <= lsws_pkg::WORD_BITS'(in_value);
		end
		if (cmd.exec) begin
			data_q  <= '0;
			found_q <= 1'b0;
			idx_q   <= '0;
			if (func_q == lsws_pkg::OP_PUSH && full) begin
				status_q <= lsws_pkg::ST_FULL;
			end else if (func_q == lsws_pkg::OP_POP && empty) begin
				status_q <= lsws_pkg::ST_EMPTY;
			end else begin
				status_q <= lsws_pkg::ST_DONE;
			end
		end
		if (cmd.pop_latch) begin
			data_q <= lsws_pkg::DATA_W'($signed(rd_data_q));
		end
		if (cmd.srch_step) begin
			idx_q <= idx_inc;
			if (sts.match) begin
				found_q <= 1'b1;
			end
		end
	end

	// output register, count and flags taken after the operation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_status_q <= status_q;
			out_data_q   <= lsws_pkg::OUT_TDATA_W'({full, empty, count_q, found_q, data_q});
		end
	end

	assign out_valid  = out_valid_q;
	assign out_data   = out_data_q;
	assign out_status = out_status_q;

endmodule

// ===== sv/bounded_stack_with_search.sv =====
// top level of the bounded stack with search: controller, datapath and stream ports
//
//  port group   dir  tdata / tuser                                   when taken
//  s_*          in   tdata: value[31:0]; tuser: func[1:0]            tvalid & tready
//  m_*          out  tdata: data, found, count, is_empty, is_full;   tvalid & tready
//                    tuser: status[1:0]
//  cfg_*        in   capacity[6:0]                                   cfg_valid & cfg_ready
//
// push and a refused operation pass through the execute and finish states after accept;
// pop passes through execute, read wait and finish; a word is done before the next is taken
// a search reads one entry per cycle from the single-port memory, from the bottom entry up,
// with an early finish on the first match
// reset empties the stack and sets capacity to 64; memory contents are not cleared
// the next word is accepted while a result waits in the output register; a result
// that cannot enter a full output register holds the controller until it drains
module bounded_stack_with_search (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [lsws_pkg::DATA_W-1:0]           s_tdata,   // value[31:0]
	input  logic [lsws_pkg::FUNC_W-1:0]           s_tuser,   // func[1:0]
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// data[31:0], found[32], count[39:33], is_empty[40], is_full[41], zero fill
	output logic [lsws_pkg::OUT_TDATA_W-1:0]      m_tdata,
	output logic [lsws_pkg::STATUS_W-1:0]         m_tuser,   // status[1:0]
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [lsws_pkg::CAP_W-1:0]            cfg_data
);

	lsws_pkg::cmd_t cmd;
	lsws_pkg::sts_t sts;

	// capacity writes are always taken
	assign cfg_ready = 1'b1;

	lsws_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lsws_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.cfg_write  (cfg_valid & cfg_ready),
		.cfg_cap    (cfg_data),
		.in_func    (s_tuser),
		.in_value   (s_tdata),
		.out_ready  (m_tready),
		.out_valid  (m_tvalid),
		.out_data   (m_tdata),
		.out_status (m_tuser)
	);

endmodule
